// File: rtl/sgdlr_pkg.sv
package sgdlr_pkg;

    localparam int VAL_W     = 32;
    localparam int MAG_W     = 33;
    localparam int PROD_W    = 66;
    localparam int IDX_OUT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [1:0] ACT_FEATURE = 2'd0;
    localparam logic [1:0] ACT_TARGET  = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_STEP = 2'd2;

    localparam logic [31:0] LR_RESET    = 32'd429497;
    localparam logic [4:0]  FC_RESET    = 5'd1;
    localparam logic [15:0] STEP_RESET  = 16'd66;

    localparam logic        KIND_SUMMARY = 1'b0;
    localparam logic        KIND_COEFF   = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [IDX_OUT_W-1:0] index;
        logic [VAL_W-1:0]     value;
        logic [VAL_W-1:0]     sq;
        logic                 sat;
        logic                 last;
    } result_t;

    // magnitude of a signed 33-bit value as unsigned 33 bits
    function automatic logic [MAG_W-1:0] mag33(input logic [MAG_W-1:0] v);
        mag33 = v[MAG_W-1] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [MAG_W-1:0] mag32(input logic [VAL_W-1:0] v);
        mag32 = mag33({v[VAL_W-1], v});
    endfunction

endpackage

// File: rtl/sgdlr_ram.sv
module sgdlr_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                        wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                        rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sgdlr_outbuf.sv
module sgdlr_outbuf (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                res_valid,
    output logic                                res_ready,
    input  sgdlr_pkg::result_t                  res_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_result_kind,
    output logic [sgdlr_pkg::IDX_OUT_W-1:0]     m_coeff_index,
    output logic signed [sgdlr_pkg::VAL_W-1:0]  m_result_value,
    output logic [sgdlr_pkg::VAL_W-1:0]         m_squared_error,
    output logic                                m_saturated,
    output logic                                m_last
);

    logic               valid_reg;
    sgdlr_pkg::result_t item_reg;

    assign res_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            item_reg <= res_item;
        end
    end

    assign m_valid         = valid_reg;
    assign m_result_kind   = item_reg.kind;
    assign m_coeff_index   = item_reg.index;
    assign m_result_value  = item_reg.value;
    assign m_squared_error = item_reg.sq;
    assign m_saturated     = item_reg.sat;
    assign m_last          = item_reg.last;

endmodule

// File: rtl/sgdlr_ctrl.sv
module sgdlr_ctrl #(
    parameter int MAX_FEATURES = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic signed [sgdlr_pkg::VAL_W-1:0]  s_sample_value,
    input  logic                                cfg_wr_en,
    input  logic [sgdlr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgdlr_pkg::CFG_W-1:0]         cfg_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output sgdlr_pkg::result_t                  res_item
);

    localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
    localparam int FA_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int GM_W   = 63 - FRAC_BITS;
    localparam int D_W    = GM_W + 1;
    localparam int NC_W   = D_W + 2;
    localparam int ACC_W  = 71 - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] P_MIN = ACC_W'(-64'sd2147483648);
    localparam logic signed [NC_W-1:0]  C_MAX = NC_W'(64'sd2147483647);
    localparam logic signed [NC_W-1:0]  C_MIN = NC_W'(-64'sd2147483648);

    typedef enum logic [3:0] {
        S_IDLE, S_P_RD, S_P_MUL, S_P_ACC, S_P_SUM, S_SQ_MUL, S_SUMMARY,
        S_U_RD, S_U_MUL, S_U_GRAD, S_U_LR1, S_U_LR2, S_U_SUB
    } state_t;

    state_t state_reg;

    logic [31:0]               lr_reg;
    logic [4:0]                fc_reg;
    logic [15:0]               h_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [MAX_FEATURES:0]     cvalid_reg;
    logic                      cval_q_reg;
    logic                      fok_q_reg;
    logic signed [31:0]        y_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [sgdlr_pkg::PROD_W-1:0] prod_reg;
    logic                      neg_reg;
    logic signed [31:0]        c_cur_reg;
    logic signed [31:0]        pred_reg;
    logic                      psat_reg;
    logic signed [32:0]        e_reg;
    logic signed [31:0]        g_reg;
    logic                      gsat_reg;
    logic [GM_W-1:0]           gm_reg;
    logic                      gneg_reg;
    logic [31:0]               lo_reg;

    logic [CNT_W-1:0]          n_feat;
    logic [CNT_W-1:0]          idx_m1;
    logic [FA_W-1:0]           feat_raddr;
    logic                      feat_we;
    logic                      coef_we;
    logic [31:0]               coef_rdata;
    logic [31:0]               feat_rdata;
    logic signed [31:0]        c_val;
    logic signed [31:0]        x_val;
    logic [sgdlr_pkg::MAG_W-1:0] mul_a;
    logic [sgdlr_pkg::MAG_W-1:0] mul_b;
    logic [sgdlr_pkg::PROD_W-1:0] prod;
    logic [ACC_W-1:0]          tmag;
    logic signed [ACC_W-1:0]   term;
    logic signed [31:0]        pred;
    logic                      pclip;
    logic [sgdlr_pkg::PROD_W-1:0] sq_full;
    logic [31:0]               sq;
    logic                      sqclip;
    logic signed [34:0]        g_w;
    logic signed [31:0]        g_sat;
    logic                      gclip;
    logic [D_W-1:0]            dm;
    logic signed [NC_W-1:0]    sd;
    logic signed [NC_W-1:0]    nc_w;
    logic signed [31:0]        nc;
    logic                      cclip;
    logic                      fire;
    logic                      at_end;

    always_comb begin
        if (int'(fc_reg) > MAX_FEATURES) begin
            n_feat = CNT_W'(MAX_FEATURES);
        end else begin
            n_feat = CNT_W'(fc_reg);
        end
    end

    assign idx_m1     = idx_reg - CNT_W'(1);
    assign feat_raddr = idx_m1[FA_W-1:0];
    assign at_end     = (idx_reg == n_feat);
    assign fire       = res_valid && res_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign feat_we    = s_valid && s_ready && (s_action == sgdlr_pkg::ACT_FEATURE)
                        && (cnt_reg < n_feat);
    assign coef_we    = (state_reg == S_U_SUB) && fire;

    sgdlr_ram #(.W(32), .D(MAX_FEATURES + 1)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (idx_reg),
        .wdata (nc),
        .raddr (idx_reg),
        .rdata (coef_rdata)
    );

    sgdlr_ram #(.W(32), .D(MAX_FEATURES)) u_feat_ram (
        .aclk  (aclk),
        .we    (feat_we),
        .waddr (cnt_reg[FA_W-1:0]),
        .wdata (s_sample_value),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    assign c_val = cval_q_reg ? coef_rdata : 32'sd0;
    assign x_val = fok_q_reg ? feat_rdata : 32'sd0;

    // shared multiplier
    always_comb begin
        unique case (state_reg)
            S_P_MUL: begin
                mul_a = sgdlr_pkg::mag32(c_val);
                mul_b = sgdlr_pkg::mag32(x_val);
            end
            S_SQ_MUL: begin
                mul_a = sgdlr_pkg::mag33(e_reg);
                mul_b = sgdlr_pkg::mag33(e_reg);
            end
            S_U_MUL: begin
                mul_a = sgdlr_pkg::mag32(g_reg);
                mul_b = sgdlr_pkg::mag32(x_val);
            end
            S_U_LR1: begin
                mul_a = 33'(gm_reg[31:0]);
                mul_b = 33'(lr_reg);
            end
            S_U_LR2: begin
                mul_a = 33'(gm_reg[GM_W-1:32]);
                mul_b = 33'(lr_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // prediction accumulate and saturation
    assign tmag = ACC_W'(prod_reg >> FRAC_BITS);
    assign term = neg_reg ? -$signed(tmag) : $signed(tmag);

    always_comb begin
        pclip = 1'b1;
        if (acc_reg > P_MAX) begin
            pred = 32'sh7FFFFFFF;
        end else if (acc_reg < P_MIN) begin
            pred = 32'sh80000000;
        end else begin
            pred  = acc_reg[31:0];
            pclip = 1'b0;
        end
    end

    assign sq_full = prod_reg >> FRAC_BITS;
    assign sqclip  = |sq_full[sgdlr_pkg::PROD_W-1:32];
    assign sq      = sqclip ? 32'hFFFFFFFF : sq_full[31:0];

    assign g_w = {{2{e_reg[32]}}, e_reg} + {{2{e_reg[32]}}, e_reg} + $signed({19'b0, h_reg});

    always_comb begin
        gclip = 1'b1;
        if (g_w > 35'sd2147483647) begin
            g_sat = 32'sh7FFFFFFF;
        end else if (g_w < -35'sd2147483648) begin
            g_sat = 32'sh80000000;
        end else begin
            g_sat = g_w[31:0];
            gclip = 1'b0;
        end
    end

    // coefficient step
    assign dm   = D_W'(prod_reg) + D_W'(lo_reg);
    assign sd   = gneg_reg ? -$signed({2'b0, dm}) : $signed({2'b0, dm});
    assign nc_w = {{(NC_W-32){c_cur_reg[31]}}, c_cur_reg} - sd;

    always_comb begin
        cclip = 1'b1;
        if (nc_w > C_MAX) begin
            nc = 32'sh7FFFFFFF;
        end else if (nc_w < C_MIN) begin
            nc = 32'sh80000000;
        end else begin
            nc    = nc_w[31:0];
            cclip = 1'b0;
        end
    end

    always_comb begin
        res_valid = (state_reg == S_SUMMARY) || (state_reg == S_U_SUB);
        if (state_reg == S_SUMMARY) begin
            res_item.kind  = sgdlr_pkg::KIND_SUMMARY;
            res_item.index = '0;
            res_item.value = pred_reg;
            res_item.sq    = sq;
            res_item.sat   = psat_reg || sqclip;
            res_item.last  = 1'b0;
        end else begin
            res_item.kind  = sgdlr_pkg::KIND_COEFF;
            res_item.index = sgdlr_pkg::IDX_OUT_W'(idx_reg);
            res_item.value = nc;
            res_item.sq    = '0;
            res_item.sat   = gsat_reg || cclip;
            res_item.last  = at_end;
        end
    end

    always_ff @(posedge aclk) begin
        cval_q_reg <= cvalid_reg[idx_reg];
        fok_q_reg  <= (idx_reg != '0) && (idx_m1 < cnt_reg);
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            lr_reg     <= sgdlr_pkg::LR_RESET;
            fc_reg     <= sgdlr_pkg::FC_RESET;
            h_reg      <= sgdlr_pkg::STEP_RESET;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            cvalid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sgdlr_pkg::REG_LEARNING_RATE:   lr_reg <= cfg_data[31:0];
                    sgdlr_pkg::REG_FEATURE_COUNT:   fc_reg <= cfg_data[4:0];
                    sgdlr_pkg::REG_DERIVATIVE_STEP: h_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    idx_reg <= '0;
                    if (s_valid) begin
                        unique case (s_action)
                            sgdlr_pkg::ACT_FEATURE: begin
                                if (cnt_reg < n_feat) begin
                                    cnt_reg <= cnt_reg + CNT_W'(1);
                                end
                            end
                            sgdlr_pkg::ACT_TARGET: begin
                                y_reg     <= s_sample_value;
                                acc_reg   <= '0;
                                state_reg <= S_P_RD;
                            end
                            sgdlr_pkg::ACT_CLEAR: cvalid_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                S_P_RD: state_reg <= S_P_MUL;
                S_P_MUL: begin
                    prod_reg  <= prod;
                    neg_reg   <= c_val[31] ^ x_val[31];
                    c_cur_reg <= c_val;
                    state_reg <= S_P_ACC;
                end
                S_P_ACC: begin
                    if (idx_reg == '0) begin
                        acc_reg <= acc_reg + ACC_W'(c_cur_reg);
                    end else begin
                        acc_reg <= acc_reg + term;
                    end
                    if (at_end) begin
                        state_reg <= S_P_SUM;
                    end else begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_P_RD;
                    end
                end
                S_P_SUM: begin
                    pred_reg  <= pred;
                    psat_reg  <= pclip;
                    e_reg     <= {pred[31], pred} - {y_reg[31], y_reg};
                    state_reg <= S_SQ_MUL;
                end
                S_SQ_MUL: begin
                    prod_reg  <= prod;
                    state_reg <= S_SUMMARY;
                end
                S_SUMMARY: begin
                    if (fire) begin
                        g_reg     <= g_sat;
                        gsat_reg  <= gclip;
                        idx_reg   <= '0;
                        state_reg <= S_U_RD;
                    end
                end
                S_U_RD: state_reg <= S_U_MUL;
                S_U_MUL: begin
                    prod_reg  <= prod;
                    neg_reg   <= g_reg[31] ^ x_val[31];
                    c_cur_reg <= c_val;
                    state_reg <= S_U_GRAD;
                end
                S_U_GRAD: begin
                    if (idx_reg == '0) begin
                        gm_reg   <= GM_W'(sgdlr_pkg::mag32(g_reg));
                        gneg_reg <= g_reg[31];
                    end else begin
                        gm_reg   <= GM_W'(prod_reg >> FRAC_BITS);
                        gneg_reg <= neg_reg;
                    end
                    state_reg <= S_U_LR1;
                end
                S_U_LR1: begin
                    prod_reg  <= prod;
                    state_reg <= S_U_LR2;
                end
                S_U_LR2: begin
                    lo_reg    <= prod_reg[63:32];
                    prod_reg  <= prod;
                    state_reg <= S_U_SUB;
                end
                S_U_SUB: begin
                    if (fire) begin
                        cvalid_reg[idx_reg] <= 1'b1;
                        if (at_end) begin
                            cnt_reg   <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            state_reg <= S_U_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/sgd_linear_regression_update_top.sv
// channel | ports                          | role
// s_      | s_valid s_ready s_action ...   | feature, target or clear item in
// m_      | m_valid m_ready m_result_* ... | summary and coefficient items out
// cfg_    | cfg_wr_en cfg_index cfg_data   | register writes, no wait
// feature and clear items are taken while idle; a target runs a prediction pass, a
// summary item and an update pass over coefficients 0..n, n = features in use, with
// output stalls, paced by the one shared 33x33 multiplier and the registered RAM read
// reset is synchronous, active low; no clearing pass, coefficients use valid bits
// a full output register stalls the sequencer until m_ready
module sgd_linear_regression_update_top #(
    parameter int MAX_FEATURES = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic signed [sgdlr_pkg::VAL_W-1:0]  s_sample_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_result_kind,
    output logic [sgdlr_pkg::IDX_OUT_W-1:0]     m_coeff_index,
    output logic signed [sgdlr_pkg::VAL_W-1:0]  m_result_value,
    output logic [sgdlr_pkg::VAL_W-1:0]         m_squared_error,
    output logic                                m_saturated,
    output logic                                m_last,
    input  logic                                cfg_wr_en,
    input  logic [sgdlr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgdlr_pkg::CFG_W-1:0]         cfg_data
);

    logic               res_valid;
    logic               res_ready;
    sgdlr_pkg::result_t res_item;

    sgdlr_ctrl #(
        .MAX_FEATURES (MAX_FEATURES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_sample_value (s_sample_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_item       (res_item)
    );

    sgdlr_outbuf u_outbuf (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res_item        (res_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_coeff_index   (m_coeff_index),
        .m_result_value  (m_result_value),
        .m_squared_error (m_squared_error),
        .m_saturated     (m_saturated),
        .m_last          (m_last)
    );

endmodule

// File: rtl/sgdlr_checker.sv
module sgdlr_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [4:0]  m_coeff_index,
    input logic [31:0] m_result_value,
    input logic [31:0] m_squared_error,
    input logic        m_last
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_hold_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_value))
        else $error("result value changed while stalled");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_result_kind)
        else $error("last on a summary item");

    a_summary_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_kind |-> m_coeff_index == 5'd0 && !m_last)
        else $error("summary item with nonzero index");

    a_coeff_sq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind |-> m_squared_error == 32'd0)
        else $error("coefficient item with squared error");

endmodule

bind sgd_linear_regression_update_top sgdlr_assert u_sgdlr_assert (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_kind   (m_result_kind),
    .m_coeff_index   (m_coeff_index),
    .m_result_value  (m_result_value),
    .m_squared_error (m_squared_error),
    .m_last          (m_last)
);
